@@ rtl/rpc_pkg.sv @@
package rpc_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [1:0] REG_DEPTH  = 2'd0;
  localparam logic [1:0] REG_FORMAT = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  // depth codes
  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_16 = 3'd4;
  localparam logic [2:0] DEPTH_24 = 3'd5;
  localparam logic [2:0] DEPTH_32 = 3'd6;

  // format codes
  localparam logic [2:0] FMT_GREY     = 3'd0;
  localparam logic [2:0] FMT_RGB332   = 3'd1;
  localparam logic [2:0] FMT_RGB565   = 3'd0;
  localparam logic [2:0] FMT_RGB555   = 3'd1;
  localparam logic [2:0] FMT_RGB444   = 3'd2;
  localparam logic [2:0] FMT_ARGB1555 = 3'd3;
  localparam logic [2:0] FMT_BGR565   = 3'd4;
  localparam logic [2:0] FMT_BGR555   = 3'd5;
  localparam logic [2:0] FMT_BGR444   = 3'd6;
  localparam logic [2:0] FMT_RGB888   = 3'd0;
  localparam logic [2:0] FMT_RGBA8888 = 3'd0;

  localparam logic [2:0]            DEPTH_RESET  = DEPTH_24;
  localparam logic [2:0]            FORMAT_RESET = 3'd0;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd1;

  // chequerboard
  localparam logic [7:0] BG_DARK    = 8'h66;
  localparam logic [7:0] BG_LIGHT   = 8'h99;
  localparam logic [4:0] PHASE_HALF = 5'd10;
  localparam logic [4:0] PHASE_LAST = 5'd19;

  // one queue entry: either a raw byte of sub-byte pixels or a whole pixel value
  typedef struct packed {
    logic        restart;
    logic        sub;
    logic [31:0] value;
  } entry_t;

endpackage

@@ rtl/raw_pixel_to_rgb888_converter_unit.sv @@
// Raw byte stream to RGB888 pixel converter. A byte is taken in each cycle while the
// four-entry queue between byte front end and pixel back end has room; the back end
// issues one pixel per cycle unless the queue is empty or the output stalls, so pixels
// bound throughput: eight per byte at 1 bpp, four at 2 bpp, two at 4 bpp, one per 1..4
// bytes at deeper formats. Queue head to output: decode, alpha multiply, divide by 255.
// Configuration must be written only while idle; the block itself does not enforce it.
module raw_pixel_to_rgb888_converter_unit #(
  parameter int MAX_WIDTH = rpc_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tuser,   // restart
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // blue [23:16], green, red [7:0]
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [2:0]                     depth_r, format_r;
  logic [rpc_pkg::CFG_DATA_W-1:0] width_r;
  logic                           depth_clr;
  logic                           q_full, q_push, q_pop, q_empty;
  rpc_pkg::entry_t                q_in, q_head;

  assign depth_clr = cfg_wr_en && (cfg_index == rpc_pkg::REG_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= rpc_pkg::DEPTH_RESET;
      format_r <= rpc_pkg::FORMAT_RESET;
      width_r  <= rpc_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rpc_pkg::REG_DEPTH:  depth_r  <= cfg_data[2:0];
        rpc_pkg::REG_FORMAT: format_r <= cfg_data[2:0];
        rpc_pkg::REG_WIDTH:  width_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .depth     (depth_r),
    .depth_clr (depth_clr),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  rpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  rpc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .depth      (depth_r),
    .format     (format_r),
    .row_width  (width_r),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/rpc_front.sv @@
module rpc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [2:0]       depth,
  input  logic             depth_clr,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tuser,
  input  logic             q_full,
  output logic             q_push,
  output rpc_pkg::entry_t  q_data
);

  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        pend_r, pend_nxt;
  logic        accept;
  logic [2:0]  nbytes;
  logic [1:0]  lb;
  logic [23:0] acc_cur;
  logic [1:0]  idx_cur;
  logic [31:0] val;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    unique case (depth)
      rpc_pkg::DEPTH_16: nbytes = 3'd2;
      rpc_pkg::DEPTH_24: nbytes = 3'd3;
      rpc_pkg::DEPTH_32: nbytes = 3'd4;
      default:           nbytes = 3'd1;
    endcase
    lb = 2'(nbytes - 3'd1);
  end

  always_comb begin
    acc_cur  = in_tuser ? 24'd0 : acc_r;
    idx_cur  = in_tuser ? 2'd0  : idx_r;
    val      = {8'd0, acc_cur} | ({24'd0, in_tdata} << {lb, 3'b000});
    acc_nxt  = acc_r;
    idx_nxt  = idx_r;
    pend_nxt = pend_r;
    q_push   = 1'b0;
    q_data.restart = in_tuser || pend_r;
    q_data.sub     = 1'b0;
    q_data.value   = val;
    if (depth_clr) begin
      acc_nxt = 24'd0;
      idx_nxt = 2'd0;
    end
    if (accept) begin
      if (depth <= rpc_pkg::DEPTH_4) begin
        q_push       = 1'b1;
        q_data.sub   = 1'b1;
        q_data.value = {24'd0, in_tdata};
        acc_nxt      = acc_cur;
        idx_nxt      = idx_cur;
        pend_nxt     = 1'b0;
      end else if ({1'b0, idx_cur} + 3'd1 < nbytes) begin
        acc_nxt  = acc_cur | 24'({24'd0, in_tdata} << {idx_cur, 3'b000});
        idx_nxt  = idx_cur + 2'd1;
        pend_nxt = in_tuser || pend_r;
      end else begin
        q_push   = 1'b1;
        acc_nxt  = 24'd0;
        idx_nxt  = 2'd0;
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 24'd0;
      idx_r  <= 2'd0;
      pend_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

@@ rtl/rpc_queue.sv @@
module rpc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rpc_pkg::entry_t  push_data,
  output logic             full,
  input  logic             pop,
  output rpc_pkg::entry_t  head,
  output logic             empty
);

  localparam int AW = rpc_pkg::QPTR_W;
  localparam int CNT_W = AW + 1;

  rpc_pkg::entry_t mem_r [rpc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(rpc_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/rpc_back.sv @@
module rpc_back #(
  parameter int MAX_WIDTH = rpc_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [2:0]                         depth,
  input  logic [2:0]                         format,
  input  logic [rpc_pkg::CFG_DATA_W-1:0]     row_width,
  input  rpc_pkg::entry_t                    head,
  input  logic                               empty,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,
  output logic                               out_tlast
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = $clog2(MAX_WIDTH + 1);

  function automatic logic [7:0] widen2(input logic [1:0] f);
    return {f, f, f, f};
  endfunction
  function automatic logic [7:0] widen3(input logic [2:0] f);
    return {f, f, f[2:1]};
  endfunction
  function automatic logic [7:0] widen4(input logic [3:0] f);
    return {f, f};
  endfunction
  function automatic logic [7:0] widen5(input logic [4:0] f);
    return {f, f[4:2]};
  endfunction
  function automatic logic [7:0] widen6(input logic [5:0] f);
    return {f, f[5:4]};
  endfunction

  logic          adv, issue, restart_now, sub_last, wrap;
  logic [2:0]    sub_i_r, sub_i_nxt;
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [4:0]    cph_r, cph_nxt, cph_cur;
  logic [4:0]    rph_r, rph_nxt, rph_cur;
  logic [EW-1:0] eff_w;
  logic [7:0]    grey, r_d, g_d, b_d, a_d, bg_d;
  logic [31:0]   v;

  logic          s1_v_r, s2_v_r, out_v_r;
  logic [7:0]    s1_r_r, s1_g_r, s1_b_r, s1_a_r, s1_bg_r;
  logic          s1_last_r, s2_last_r, out_last_r;
  logic          s2_opq_r;
  logic [15:0]   s2_r_r, s2_g_r, s2_b_r;
  logic [23:0]   out_data_r;
  logic [7:0]    ia;
  logic          opq;

  assign adv         = !out_v_r || out_tready;
  assign issue       = adv && !empty;
  assign restart_now = head.restart && (sub_i_r == 3'd0);
  assign sub_last    = (sub_i_r == (3'd7 >> depth[1:0]));
  assign pop         = issue && (!head.sub || sub_last);

  // position of this pixel
  always_comb begin
    col_cur = restart_now ? '0   : col_r;
    cph_cur = restart_now ? 5'd0 : cph_r;
    rph_cur = restart_now ? 5'd0 : rph_r;
    if (row_width == '0) begin
      eff_w = EW'(1);
    end else if (row_width > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(row_width);
    end
    wrap = (EW'(col_cur) + EW'(1)) >= eff_w;
    if (wrap) begin
      col_nxt = '0;
      cph_nxt = 5'd0;
      rph_nxt = (rph_cur == rpc_pkg::PHASE_LAST) ? 5'd0 : rph_cur + 5'd1;
    end else begin
      col_nxt = col_cur + CW'(1);
      cph_nxt = (cph_cur == rpc_pkg::PHASE_LAST) ? 5'd0 : cph_cur + 5'd1;
      rph_nxt = rph_cur;
    end
    bg_d = ((cph_cur >= rpc_pkg::PHASE_HALF) ^ (rph_cur >= rpc_pkg::PHASE_HALF)) ?
           rpc_pkg::BG_DARK : rpc_pkg::BG_LIGHT;
    sub_i_nxt = (head.sub && !sub_last) ? sub_i_r + 3'd1 : 3'd0;
  end

  // colour decode
  always_comb begin
    v = head.value;
    unique case (depth[1:0])
      2'd0:    grey = v[{2'b00, sub_i_r}] ? 8'hFF : 8'h00;
      2'd1:    grey = widen2(v[{2'b00, sub_i_r[1:0], 1'b0} +: 2]);
      default: grey = widen4(v[{2'b00, sub_i_r[0], 2'b00} +: 4]);
    endcase
    r_d = v[7:0];
    g_d = v[7:0];
    b_d = v[7:0];
    a_d = 8'hFF;
    if (head.sub) begin
      r_d = grey;
      g_d = grey;
      b_d = grey;
    end else begin
      unique case (depth)
        rpc_pkg::DEPTH_8: begin
          if (format == rpc_pkg::FMT_RGB332) begin
            r_d = widen3(v[7:5]);
            g_d = widen3(v[4:2]);
            b_d = widen2(v[1:0]);
          end
        end
        rpc_pkg::DEPTH_16: begin
          unique case (format)
            rpc_pkg::FMT_RGB565: begin
              r_d = widen5(v[15:11]); g_d = widen6(v[10:5]); b_d = widen5(v[4:0]);
            end
            rpc_pkg::FMT_RGB555: begin
              r_d = widen5(v[14:10]); g_d = widen5(v[9:5]); b_d = widen5(v[4:0]);
            end
            rpc_pkg::FMT_RGB444: begin
              r_d = widen4(v[11:8]); g_d = widen4(v[7:4]); b_d = widen4(v[3:0]);
            end
            rpc_pkg::FMT_ARGB1555: begin
              r_d = widen5(v[14:10]); g_d = widen5(v[9:5]); b_d = widen5(v[4:0]);
              a_d = v[15] ? 8'hFF : 8'h00;
            end
            rpc_pkg::FMT_BGR565: begin
              r_d = widen5(v[4:0]); g_d = widen6(v[10:5]); b_d = widen5(v[15:11]);
            end
            rpc_pkg::FMT_BGR555: begin
              r_d = widen5(v[4:0]); g_d = widen5(v[9:5]); b_d = widen5(v[14:10]);
            end
            rpc_pkg::FMT_BGR444: begin
              r_d = widen4(v[3:0]); g_d = widen4(v[7:4]); b_d = widen4(v[11:8]);
            end
            default: begin
            end
          endcase
        end
        rpc_pkg::DEPTH_24: begin
          if (format == rpc_pkg::FMT_RGB888) begin
            r_d = v[23:16]; g_d = v[15:8]; b_d = v[7:0];
          end
        end
        rpc_pkg::DEPTH_32: begin
          if (format == rpc_pkg::FMT_RGBA8888) begin
            r_d = v[31:24]; g_d = v[23:16]; b_d = v[15:8]; a_d = v[7:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

  function automatic logic [15:0] mix(input logic [7:0] c, input logic [7:0] a,
                                      input logic [7:0] na, input logic [7:0] bg);
    return ({8'd0, c} * {8'd0, a}) + ({8'd0, bg} * {8'd0, na});
  endfunction

  assign opq = (s1_a_r == 8'hFF);
  assign ia  = 8'hFF - s1_a_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r_r    <= r_d;
      s1_g_r    <= g_d;
      s1_b_r    <= b_d;
      s1_a_r    <= a_d;
      s1_bg_r   <= bg_d;
      s1_last_r <= !head.sub || sub_last;
      s2_opq_r  <= opq;
      s2_last_r <= s1_last_r;
      s2_r_r    <= opq ? {8'd0, s1_r_r} : mix(s1_r_r, s1_a_r, ia, s1_bg_r);
      s2_g_r    <= opq ? {8'd0, s1_g_r} : mix(s1_g_r, s1_a_r, ia, s1_bg_r);
      s2_b_r    <= opq ? {8'd0, s1_b_r} : mix(s1_b_r, s1_a_r, ia, s1_bg_r);
      out_last_r <= s2_last_r;
      if (s2_opq_r) begin
        out_data_r <= {s2_b_r[7:0], s2_g_r[7:0], s2_r_r[7:0]};
      end else begin
        out_data_r <= {div255(s2_b_r), div255(s2_g_r), div255(s2_r_r)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      sub_i_r <= 3'd0;
      col_r   <= '0;
      cph_r   <= 5'd0;
      rph_r   <= 5'd0;
    end else begin
      if (adv) begin
        s1_v_r  <= issue;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
      if (issue) begin
        sub_i_r <= sub_i_nxt;
        col_r   <= col_nxt;
        cph_r   <= cph_nxt;
        rph_r   <= rph_nxt;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
